>>> src/trl_pkg.sv
// Package for the thick line rasterizer: shared types and default constants.
`timescale 1ns / 1ps

package trl_pkg;

  localparam int SCREEN_SIZE_DEF = 480;
  localparam int MAX_RADIUS_DEF  = 31;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [10:0] start_x;
    logic signed [10:0] start_y;
    logic signed [10:0] end_x;
    logic signed [10:0] end_y;
    logic [5:0]         pen_width;
    logic [15:0]        pen_color;
  } item_t;

  typedef struct packed {
    logic [8:0]  pixel_x;
    logic [8:0]  pixel_y;
    logic [15:0] pixel_color;
    logic        write_enable;
    logic        done_res;
  } pix_t;

endpackage

>>> src/trl_core.sv
// Line walker and disc scanner: holds the line state and forms one pixel result per step.
`timescale 1ns / 1ps

module trl_core #(
  parameter int SCREEN_SIZE = trl_pkg::SCREEN_SIZE_DEF,
  parameter int MAX_RADIUS  = trl_pkg::MAX_RADIUS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  trl_pkg::item_t item,
  output logic           res_valid,
  output trl_pkg::pix_t  res
);
  import trl_pkg::*;

  localparam logic [11:0] SCR_LIM = 12'(SCREEN_SIZE);
  localparam logic [6:0]  RAD_LIM = 7'(MAX_RADIUS);

  logic               busy_r;
  logic signed [10:0] point_x_r, point_y_r, target_x_r, target_y_r;
  logic [10:0]        adx_r;
  logic signed [11:0] ndy_r;
  logic               dirx_neg_r, diry_neg_r;
  logic signed [12:0] err_r;
  logic [4:0]         radius_r;
  logic [9:0]         rsq_r;
  logic signed [5:0]  sx_r, sy_r;
  logic [15:0]        color_r;

  logic [4:0]         r_raw, r_sat;
  logic signed [11:0] ddx, ddy;
  logic [10:0]        adx_new;
  logic signed [11:0] ndy_new;
  logic signed [12:0] err_new;
  logic [9:0]         rsq_new;

  logic signed [11:0] px, py;
  logic signed [11:0] sqx, sqy;
  logic [10:0]        d2;
  logic               in_disc, onscreen, we;
  logic signed [5:0]  rad6;
  logic               last_pos, last_point;
  logic signed [13:0] e2, ndy14, adx14, err_sum;
  logic               cond_x, cond_y;

  always_comb begin
    r_raw   = item.pen_width[5:1];
    r_sat   = ({2'b00, r_raw} > RAD_LIM) ? RAD_LIM[4:0] : r_raw;
    ddx     = $signed({item.end_x[10], item.end_x}) - $signed({item.start_x[10], item.start_x});
    ddy     = $signed({item.end_y[10], item.end_y}) - $signed({item.start_y[10], item.start_y});
    adx_new = ddx[11] ? 11'(-ddx) : ddx[10:0];
    ndy_new = ddy[11] ? ddy : -ddy;
    err_new = $signed({2'b00, adx_new}) + $signed({ndy_new[11], ndy_new});
    rsq_new = r_sat * r_sat;
  end

  always_comb begin
    px       = $signed({point_x_r[10], point_x_r}) + $signed({{6{sx_r[5]}}, sx_r});
    py       = $signed({point_y_r[10], point_y_r}) + $signed({{6{sy_r[5]}}, sy_r});
    sqx      = sx_r * sx_r;
    sqy      = sy_r * sy_r;
    d2       = 11'(sqx[9:0]) + 11'(sqy[9:0]);
    in_disc  = d2 <= {1'b0, rsq_r};
    onscreen = !px[11] && ({1'b0, px[10:0]} < SCR_LIM) &&
               !py[11] && ({1'b0, py[10:0]} < SCR_LIM);
    we       = in_disc && onscreen;
    rad6     = $signed({1'b0, radius_r});
    last_pos   = (sx_r == rad6) && (sy_r == rad6);
    last_point = (point_x_r == target_x_r) && (point_y_r == target_y_r);
    e2       = $signed({err_r, 1'b0});
    ndy14    = $signed({{2{ndy_r[11]}}, ndy_r});
    adx14    = $signed({3'b000, adx_r});
    cond_x   = e2 >= ndy14;
    cond_y   = e2 <= adx14;
    err_sum  = $signed({err_r[12], err_r}) + (cond_x ? ndy14 : 14'sd0) +
               (cond_y ? adx14 : 14'sd0);

    res_valid        = fire && (item.cmd == CMD_STEP) && busy_r;
    res.pixel_x      = we ? px[8:0] : 9'd0;
    res.pixel_y      = we ? py[8:0] : 9'd0;
    res.pixel_color  = we ? color_r : 16'd0;
    res.write_enable = we;
    res.done_res     = last_pos && last_point;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (fire) begin
      if (item.cmd == CMD_START) begin
        busy_r <= 1'b1;
      end else if (busy_r && last_pos && last_point) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (item.cmd == CMD_START) begin
        point_x_r  <= item.start_x;
        point_y_r  <= item.start_y;
        target_x_r <= item.end_x;
        target_y_r <= item.end_y;
        adx_r      <= adx_new;
        ndy_r      <= ndy_new;
        dirx_neg_r <= !(item.start_x < item.end_x);
        diry_neg_r <= !(item.start_y < item.end_y);
        err_r      <= err_new;
        radius_r   <= r_sat;
        rsq_r      <= rsq_new;
        sx_r       <= -$signed({1'b0, r_sat});
        sy_r       <= -$signed({1'b0, r_sat});
        color_r    <= item.pen_color;
      end else if (busy_r) begin
        if (!last_pos) begin
          if (sx_r < rad6) begin
            sx_r <= sx_r + 6'sd1;
          end else begin
            sx_r <= -rad6;
            sy_r <= sy_r + 6'sd1;
          end
        end else if (!last_point) begin
          err_r <= err_sum[12:0];
          if (cond_x) begin
            point_x_r <= dirx_neg_r ? point_x_r - 11'sd1 : point_x_r + 11'sd1;
          end
          if (cond_y) begin
            point_y_r <= diry_neg_r ? point_y_r - 11'sd1 : point_y_r + 11'sd1;
          end
          sx_r <= -rad6;
          sy_r <= -rad6;
        end
      end
    end
  end

endmodule

>>> src/trl_obuf.sv
// Two-entry result queue that decouples the result channel from the line walker.
`timescale 1ns / 1ps

module trl_obuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  trl_pkg::pix_t push_data,
  output logic          room,
  output logic          pop_valid,
  input  logic          pop_ready,
  output trl_pkg::pix_t pop_data
);
  import trl_pkg::*;

  pix_t       entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign room      = (cnt_r != 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_data  = entry_r[rd_ptr_r];
  assign do_pop    = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> src/thick_line_rasterizer.sv
// Top level of the thick line rasterizer: input register, line walker and result queue.
//
// The input channel takes commands with valid/ready. A start transaction loads both
// endpoints, the pen width and the colour and produces no result. Each step transaction
// produces one result for the current position of the disc scan around the current point
// of the line; a step while no line is loaded produces nothing. The result channel carries
// pixel_x, pixel_y, pixel_color, write_enable and done_res with valid/ready; done_res marks
// the last position of the last point, after which the block is idle.
// An input transaction passes the input register and then the result queue before it
// reaches the output. Throughput is one transaction per cycle while the queue has room,
// set by the state update of the line walker.
// The two-entry result queue keeps accepting while one result waits; when the receiver
// stalls and the queue is full, in_ready falls and the pending transaction is held.
// Reset is synchronous and active low; it empties the queue and the input register and
// leaves the block with no line loaded.
`timescale 1ns / 1ps

module thick_line_rasterizer #(
  parameter int SCREEN_SIZE = trl_pkg::SCREEN_SIZE_DEF,
  parameter int MAX_RADIUS  = trl_pkg::MAX_RADIUS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [10:0] in_start_x,
  input  logic [10:0] in_start_y,
  input  logic [10:0] in_end_x,
  input  logic [10:0] in_end_y,
  input  logic [5:0]  in_pen_width,
  input  logic [15:0] in_pen_color,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [8:0]  out_pixel_x,
  output logic [8:0]  out_pixel_y,
  output logic [15:0] out_pixel_color,
  output logic        out_write_enable,
  output logic        out_done_res
);
  import trl_pkg::*;

  logic  stg_valid_r;
  item_t stg_r;
  logic  room, advance, res_valid;
  pix_t  res, out_data;

  assign advance  = stg_valid_r && room;
  assign in_ready = !stg_valid_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_r.cmd       <= cmd_t'(in_cmd);
      stg_r.start_x   <= $signed(in_start_x);
      stg_r.start_y   <= $signed(in_start_y);
      stg_r.end_x     <= $signed(in_end_x);
      stg_r.end_y     <= $signed(in_end_y);
      stg_r.pen_width <= in_pen_width;
      stg_r.pen_color <= in_pen_color;
    end
  end

  trl_core #(
    .SCREEN_SIZE(SCREEN_SIZE),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (advance),
    .item     (stg_r),
    .res_valid(res_valid),
    .res      (res)
  );

  trl_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_data(res),
    .room     (room),
    .pop_valid(out_valid),
    .pop_ready(out_ready),
    .pop_data (out_data)
  );

  assign out_pixel_x      = out_data.pixel_x;
  assign out_pixel_y      = out_data.pixel_y;
  assign out_pixel_color  = out_data.pixel_color;
  assign out_write_enable = out_data.write_enable;
  assign out_done_res     = out_data.done_res;

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |->
      out_pixel_x == 9'd0 && out_pixel_y == 9'd0 && out_pixel_color == 16'd0)
    else $error("Result without a write carries a non-zero pixel.");

  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("Input stalled while no result is pending.");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid_r && !room |=> stg_valid_r && $stable(stg_r))
    else $error("Stalled input register lost or changed its transaction.");

endmodule
